// ===== hw/rtl/stft_pkg.sv =====
`timescale 1ns / 1ps
// ============================================================================
// stft_pkg: shared types, constants and tables of the STFT frame engine
// Holds the register map, the datapath command encoding and the twiddle table.
// ============================================================================
package stft_pkg;

  localparam int MaxFftPoints = 64;
  localparam int SampleBits   = 16;
  localparam int RingAw       = 6;
  localparam int WinAw        = 6;
  localparam int CfgAw        = 4;
  localparam int CfgDw        = 32;

  // Register indexes (byte address is four times the index).
  localparam logic [1:0] REG_WINDOW_LENGTH  = 2'd0;
  localparam logic [1:0] REG_OVERLAP_LENGTH = 2'd1;
  localparam logic [1:0] REG_FFT_SIZE_LOG2  = 2'd2;
  localparam logic [1:0] REG_FREQ_RANGE     = 2'd3;

  // Bin order codes.
  localparam logic [1:0] RANGE_TWOSIDED = 2'd0;
  localparam logic [1:0] RANGE_ONESIDED = 2'd1;
  localparam logic [1:0] RANGE_CENTERED = 2'd2;

  localparam logic [6:0] RST_WINDOW_LENGTH  = 7'd64;
  localparam logic [5:0] RST_OVERLAP_LENGTH = 6'd48;
  localparam logic [2:0] RST_FFT_SIZE_LOG2  = 3'd6;
  localparam logic [1:0] RST_FREQ_RANGE     = RANGE_CENTERED;

  typedef struct packed {
    logic [6:0] window_length;
    logic [5:0] overlap_length;
    logic [2:0] fft_size_log2;
    logic [1:0] freq_range;
  } cfg_t;

  typedef enum logic [3:0] {
    OP_IDLE,
    OP_RING_WR,
    OP_WIN_WR,
    OP_LD_RD,
    OP_LD_WR,
    OP_BF_RD,
    OP_BF_M1,
    OP_BF_M2,
    OP_BF_M3,
    OP_BF_WS,
    OP_BF_WT,
    OP_EM_RD,
    OP_EM_OUT,
    OP_ERR_OUT
  } dp_op_e;

  typedef struct packed {
    dp_op_e      op;
    logic [5:0]  ring_addr;
    logic [5:0]  win_addr;
    logic [5:0]  addr_a;
    logic [5:0]  addr_b;
    logic [5:0]  tw_idx;
    logic        zero;
    logic [15:0] frame;
    logic [5:0]  row;
    logic        last;
  } dp_cmd_t;

  typedef struct packed {
    logic out_busy;
  } dp_stat_t;

  // First quadrant of the cosine in Q1.15, with 1.0 held as 32767.
  function automatic logic signed [15:0] quarter_cos(input logic [4:0] m);
    logic signed [15:0] v;
    case (m)
      5'd0:    v = 16'sd32767;
      5'd1:    v = 16'sd32610;
      5'd2:    v = 16'sd32138;
      5'd3:    v = 16'sd31357;
      5'd4:    v = 16'sd30274;
      5'd5:    v = 16'sd28899;
      5'd6:    v = 16'sd27246;
      5'd7:    v = 16'sd25330;
      5'd8:    v = 16'sd23170;
      5'd9:    v = 16'sd20788;
      5'd10:   v = 16'sd18205;
      5'd11:   v = 16'sd15447;
      5'd12:   v = 16'sd12540;
      5'd13:   v = 16'sd9512;
      5'd14:   v = 16'sd6393;
      5'd15:   v = 16'sd3212;
      default: v = 16'sd0;
    endcase
    return v;
  endfunction

  // Cosine of 2*pi*m/64, built from the quarter table by symmetry.
  function automatic logic signed [15:0] cos64(input logic [5:0] m);
    logic signed [15:0] v;
    if (m <= 6'd16) begin
      v = quarter_cos(5'(m));
    end else if (m <= 6'd32) begin
      v = -quarter_cos(5'(6'd32 - m));
    end else if (m <= 6'd48) begin
      v = -quarter_cos(5'(m - 6'd32));
    end else begin
      v = quarter_cos(5'(7'd64 - {1'b0, m}));
    end
    return v;
  endfunction

endpackage

// ===== hw/rtl/stft_if.sv =====
`timescale 1ns / 1ps
// ============================================================================
// stft_if: valid/ready channels of the STFT frame engine
// One interface for the input items and one for the result beats.
// ============================================================================
interface stft_in_if;
  logic               valid;
  logic               ready;
  logic               req_type;
  logic               first_of_signal;
  logic signed [15:0] sample;
  logic [5:0]         coef_index;
  logic signed [15:0] coef_value;

  modport source (output valid, req_type, first_of_signal, sample, coef_index, coef_value,
                  input ready);
  modport sink (input valid, req_type, first_of_signal, sample, coef_index, coef_value,
                output ready);
endinterface

interface stft_out_if;
  logic               valid;
  logic               ready;
  logic               status;
  logic [15:0]        frame_number;
  logic [5:0]         bin_position;
  logic signed [23:0] bin_real;
  logic signed [23:0] bin_imag;
  logic               last_bin;

  modport source (output valid, status, frame_number, bin_position, bin_real, bin_imag,
                  last_bin, input ready);
  modport sink (input valid, status, frame_number, bin_position, bin_real, bin_imag,
                last_bin, output ready);
endinterface

// ===== hw/rtl/stft_dp.sv =====
`timescale 1ns / 1ps
// ============================================================================
// stft_dp: STFT datapath
// Window table, sample ring, work memory, butterfly unit and result register.
// ============================================================================
module stft_dp #(
  parameter int LGMAX       = 6,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  stft_pkg::dp_cmd_t   cmd_i,
  output stft_pkg::dp_stat_t  stat_o,
  input  logic signed [15:0]  sample_i,
  input  logic signed [15:0]  coef_value_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic                out_status_o,
  output logic [15:0]         out_frame_o,
  output logic [5:0]          out_pos_o,
  output logic signed [23:0]  out_real_o,
  output logic signed [23:0]  out_imag_o,
  output logic                out_last_o
);
  import stft_pkg::*;

  // Internal word width leaves room for the growth of a 64-point transform.
  localparam int DW = SAMPLE_BITS + 9;
  localparam int WD = 1 << LGMAX;
  localparam int PW = SAMPLE_BITS + 17;
  localparam logic signed [PW-1:0] LD_BIAS = PW'(1 << 13);
  localparam logic signed [DW+16:0] BF_BIAS = (DW+17)'(1 << 14);
  localparam logic signed [DW+24:0] SAT_HI = (DW+25)'(8388607);
  localparam logic signed [DW+24:0] SAT_LO = -(DW+25)'(8388608);

  logic signed [15:0]          win_mem  [64];
  logic signed [SAMPLE_BITS-1:0] ring_mem [64];
  logic [2*DW-1:0]             work_mem [WD];

  logic signed [SAMPLE_BITS-1:0] smp;
  logic signed [SAMPLE_BITS-1:0] x_q;
  logic signed [15:0]          w_q;
  logic [2*DW-1:0]             a_q, b_q;
  logic signed [DW+15:0]       p0_q, p1_q;
  logic signed [DW-1:0]        tr_q, ti_q;

  logic signed [SAMPLE_BITS+15:0] ld_mul;
  logic signed [PW-1:0]        ld_sum;
  logic signed [DW-1:0]        ld_v;
  logic signed [15:0]          wr, wi;
  logic signed [DW-1:0]        are, aim, bre, bim;
  logic signed [DW+16:0]       tr_sum, ti_sum;
  logic signed [DW+24:0]       sat_re, sat_im;
  logic signed [23:0]          bin_re, bin_im;
  logic [LGMAX-1:0]            ia, ib;
  logic                        out_valid_q;
  logic                        busy;

  generate
    if (SAMPLE_BITS <= 16) begin : g_smp_narrow
      assign smp = sample_i[SAMPLE_BITS-1:0];
    end else begin : g_smp_wide
      assign smp = {{(SAMPLE_BITS-16){1'b0}}, sample_i};
    end
  endgenerate

  assign ia = cmd_i.addr_a[LGMAX-1:0];
  assign ib = cmd_i.addr_b[LGMAX-1:0];
  assign wr = cos64(cmd_i.tw_idx);
  assign wi = -cos64(cmd_i.tw_idx + 6'd48);
  assign are = a_q[2*DW-1:DW];
  assign aim = a_q[DW-1:0];
  assign bre = b_q[2*DW-1:DW];
  assign bim = b_q[DW-1:0];

  always_comb begin
    ld_mul = x_q * w_q;
    ld_sum = ld_mul + LD_BIAS;
    ld_sum = ld_sum >>> 14;
    ld_v   = cmd_i.zero ? '0 : ld_sum[DW-1:0];
    tr_sum = p0_q - p1_q + BF_BIAS;
    tr_sum = tr_sum >>> 15;
    ti_sum = p0_q + p1_q + BF_BIAS;
    ti_sum = ti_sum >>> 15;
    sat_re = (DW+25)'(are);
    sat_im = (DW+25)'(aim);
    if (sat_re > SAT_HI) sat_re = SAT_HI;
    if (sat_re < SAT_LO) sat_re = SAT_LO;
    if (sat_im > SAT_HI) sat_im = SAT_HI;
    if (sat_im < SAT_LO) sat_im = SAT_LO;
    bin_re = sat_re[23:0];
    bin_im = sat_im[23:0];
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      OP_RING_WR: ring_mem[cmd_i.ring_addr] <= smp;
      OP_WIN_WR:  win_mem[cmd_i.win_addr] <= coef_value_i;
      OP_LD_RD: begin
        x_q <= ring_mem[cmd_i.ring_addr];
        w_q <= win_mem[cmd_i.win_addr];
      end
      OP_LD_WR: work_mem[ia] <= {ld_v, {DW{1'b0}}};
      OP_BF_RD: begin
        a_q <= work_mem[ia];
        b_q <= work_mem[ib];
      end
      OP_BF_M1: begin
        p0_q <= wr * bre;
        p1_q <= wi * bim;
      end
      OP_BF_M2: begin
        tr_q <= tr_sum[DW-1:0];
        p0_q <= wr * bim;
        p1_q <= wi * bre;
      end
      OP_BF_M3: ti_q <= ti_sum[DW-1:0];
      OP_BF_WS: work_mem[ia] <= {DW'(are + tr_q), DW'(aim + ti_q)};
      OP_BF_WT: work_mem[ib] <= {DW'(are - tr_q), DW'(aim - ti_q)};
      OP_EM_RD: a_q <= work_mem[ia];
      default: ;
    endcase
  end

  // Result register: holds one beat while the sink stalls.
  assign busy = out_valid_q && !out_ready_i;
  assign stat_o.out_busy = busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.op == OP_EM_OUT || cmd_i.op == OP_ERR_OUT) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == OP_EM_OUT) begin
      out_status_o <= 1'b0;
      out_frame_o  <= cmd_i.frame;
      out_pos_o    <= cmd_i.row;
      out_real_o   <= bin_re;
      out_imag_o   <= bin_im;
      out_last_o   <= cmd_i.last;
    end else if (cmd_i.op == OP_ERR_OUT) begin
      out_status_o <= 1'b1;
      out_frame_o  <= '0;
      out_pos_o    <= '0;
      out_real_o   <= '0;
      out_imag_o   <= '0;
      out_last_o   <= 1'b1;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// ===== hw/rtl/stft_ctrl.sv =====
`timescale 1ns / 1ps
// ============================================================================
// stft_ctrl: STFT sequencer
// Framing counters and the state machine that steps the datapath.
// ============================================================================
module stft_ctrl #(
  parameter int LGMAX = 6
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  stft_pkg::cfg_t     cfg_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               in_req_type_i,
  input  logic               in_first_i,
  input  logic [5:0]         in_coef_index_i,
  input  stft_pkg::dp_stat_t stat_i,
  output stft_pkg::dp_cmd_t  cmd_o
);
  import stft_pkg::*;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_ERR    = 4'd1;
  localparam logic [3:0] S_LD_RD  = 4'd2;
  localparam logic [3:0] S_LD_WR  = 4'd3;
  localparam logic [3:0] S_BF_RD  = 4'd4;
  localparam logic [3:0] S_BF_M1  = 4'd5;
  localparam logic [3:0] S_BF_M2  = 4'd6;
  localparam logic [3:0] S_BF_M3  = 4'd7;
  localparam logic [3:0] S_BF_WS  = 4'd8;
  localparam logic [3:0] S_BF_WT  = 4'd9;
  localparam logic [3:0] S_EM_RD  = 4'd10;
  localparam logic [3:0] S_EM_OUT = 4'd11;

  logic [3:0]       state_q, state_d;
  logic [6:0]       ss_q, ss_d;
  logic [5:0]       hop_q, hop_d;
  logic [15:0]      fc_q, fc_d;
  logic             err_q, err_d;
  logic [LGMAX-1:0] cnt_q, cnt_d;
  logic [2:0]       st_q, st_d;

  logic [2:0]       lg;
  logic [LGMAX-1:0] nm1;
  logic [7:0]       nfft;
  logic             bad;
  logic             acc;
  logic [6:0]       ss_base;
  logic [7:0]       ss_inc;
  logic [6:0]       ss_new;
  logic [5:0]       hop_base;
  logic [15:0]      fc_base;
  logic             err_base;
  logic [LGMAX-1:0] rev_full, rev;
  logic [LGMAX-1:0] hmask, jj, ss_idx, tt_idx, bb;
  logic [LGMAX:0]   shift, rlast, bsum;
  logic [5:0]       base;
  logic             k_last, r_last;

  assign lg   = (cfg_i.fft_size_log2 > 3'(LGMAX)) ? 3'(LGMAX) : cfg_i.fft_size_log2;
  assign nm1  = {LGMAX{1'b1}} >> (3'(LGMAX) - lg);
  assign nfft = 8'd1 << lg;
  assign bad  = ({1'b0, cfg_i.overlap_length} >= cfg_i.window_length) ||
                (nfft < {1'b0, cfg_i.window_length});
  assign in_ready_o = (state_q == S_IDLE);
  assign acc = in_valid_i && in_ready_o;

  always_comb begin
    ss_base  = in_first_i ? '0 : ss_q;
    hop_base = in_first_i ? '0 : hop_q;
    fc_base  = in_first_i ? '0 : fc_q;
    err_base = in_first_i ? 1'b0 : err_q;
    ss_inc   = {1'b0, ss_base} + 8'd1;
    ss_new   = ss_inc[7] ? 7'(ss_inc - 8'd64) : ss_inc[6:0];
    for (int b = 0; b < LGMAX; b++) begin
      rev_full[b] = cnt_q[LGMAX-1-b];
    end
    rev    = rev_full >> (3'(LGMAX) - lg);
    base   = ss_q[5:0] - cfg_i.window_length[5:0];
    hmask  = {LGMAX{1'b1}} << st_q;
    jj     = cnt_q & ~hmask;
    ss_idx = ((cnt_q & hmask) << 1) | jj;
    tt_idx = ss_idx | (LGMAX'(1) << st_q);
    shift  = (cfg_i.freq_range == RANGE_CENTERED) ? (LGMAX+1)'(nm1 >> 1) + (LGMAX+1)'(2) : '0;
    bsum   = {1'b0, cnt_q} + shift;
    bb     = bsum[LGMAX-1:0] & nm1;
    // The one-sided order ends at row N/2, which is row 0 for a one-point transform.
    rlast  = (cfg_i.freq_range == RANGE_ONESIDED) ? (LGMAX+1)'(nfft >> 1)
                                                  : {1'b0, nm1};
    k_last = (cnt_q == (nm1 >> 1));
    r_last = ({1'b0, cnt_q} == rlast);
  end

  always_comb begin
    cmd_o           = '0;
    cmd_o.op        = OP_IDLE;
    cmd_o.ring_addr = base + 6'(rev);
    cmd_o.win_addr  = 6'(rev);
    cmd_o.addr_a    = 6'(cnt_q);
    cmd_o.addr_b    = 6'(tt_idx);
    cmd_o.tw_idx    = 6'(jj) << (3'd5 - st_q);
    cmd_o.zero      = ({{(7-LGMAX){1'b0}}, rev} >= cfg_i.window_length);
    cmd_o.frame     = fc_q;
    cmd_o.row       = 6'(cnt_q);
    cmd_o.last      = r_last;
    state_d = state_q;
    ss_d    = ss_q;
    hop_d   = hop_q;
    fc_d    = fc_q;
    err_d   = err_q;
    cnt_d   = cnt_q;
    st_d    = st_q;
    case (state_q)
      S_IDLE: begin
        if (acc && in_req_type_i) begin
          cmd_o.op       = OP_WIN_WR;
          cmd_o.win_addr = in_coef_index_i;
        end else if (acc) begin
          cmd_o.op        = OP_RING_WR;
          cmd_o.ring_addr = ss_base[5:0];
          ss_d  = ss_new;
          hop_d = hop_base;
          fc_d  = fc_base;
          err_d = err_base;
          if (bad) begin
            if (!err_base) begin
              err_d   = 1'b1;
              state_d = S_ERR;
            end
          end else if (ss_new >= cfg_i.window_length) begin
            if (hop_base != 6'd0) begin
              hop_d = hop_base - 6'd1;
            end else begin
              hop_d   = 6'(cfg_i.window_length - {1'b0, cfg_i.overlap_length} - 7'd1);
              cnt_d   = '0;
              state_d = S_LD_RD;
            end
          end
        end
      end
      S_ERR: begin
        if (!stat_i.out_busy) begin
          cmd_o.op = OP_ERR_OUT;
          state_d  = S_IDLE;
        end
      end
      S_LD_RD: begin
        cmd_o.op = OP_LD_RD;
        state_d  = S_LD_WR;
      end
      S_LD_WR: begin
        cmd_o.op = OP_LD_WR;
        if (cnt_q == nm1) begin
          cnt_d   = '0;
          st_d    = '0;
          state_d = (lg == 3'd0) ? S_EM_RD : S_BF_RD;
        end else begin
          cnt_d   = cnt_q + LGMAX'(1);
          state_d = S_LD_RD;
        end
      end
      S_BF_RD: begin
        cmd_o.op     = OP_BF_RD;
        cmd_o.addr_a = 6'(ss_idx);
        state_d      = S_BF_M1;
      end
      S_BF_M1: begin
        cmd_o.op = OP_BF_M1;
        state_d  = S_BF_M2;
      end
      S_BF_M2: begin
        cmd_o.op = OP_BF_M2;
        state_d  = S_BF_M3;
      end
      S_BF_M3: begin
        cmd_o.op = OP_BF_M3;
        state_d  = S_BF_WS;
      end
      S_BF_WS: begin
        cmd_o.op     = OP_BF_WS;
        cmd_o.addr_a = 6'(ss_idx);
        state_d      = S_BF_WT;
      end
      S_BF_WT: begin
        cmd_o.op = OP_BF_WT;
        if (k_last) begin
          cnt_d = '0;
          if (st_q == lg - 3'd1) begin
            state_d = S_EM_RD;
          end else begin
            st_d    = st_q + 3'd1;
            state_d = S_BF_RD;
          end
        end else begin
          cnt_d   = cnt_q + LGMAX'(1);
          state_d = S_BF_RD;
        end
      end
      S_EM_RD: begin
        cmd_o.op     = OP_EM_RD;
        cmd_o.addr_a = 6'(bb);
        state_d      = S_EM_OUT;
      end
      S_EM_OUT: begin
        if (!stat_i.out_busy) begin
          cmd_o.op = OP_EM_OUT;
          if (r_last) begin
            fc_d    = fc_q + 16'd1;
            cnt_d   = '0;
            state_d = S_IDLE;
          end else begin
            cnt_d   = cnt_q + LGMAX'(1);
            state_d = S_EM_RD;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ss_q    <= '0;
      hop_q   <= '0;
      fc_q    <= '0;
      err_q   <= 1'b0;
      cnt_q   <= '0;
      st_q    <= '0;
    end else begin
      state_q <= state_d;
      ss_q    <= ss_d;
      hop_q   <= hop_d;
      fc_q    <= fc_d;
      err_q   <= err_d;
      cnt_q   <= cnt_d;
      st_q    <= st_d;
    end
  end

endmodule

// ===== hw/rtl/stft_frame_engine_unit.sv =====
`timescale 1ns / 1ps
// ============================================================================
// stft_frame_engine_unit: streaming short-time Fourier transform
// Frames real samples, applies a loaded window, runs a radix-2 FFT and
// streams the bins out in twosided, onesided or centered order.
// ============================================================================
//
// Channel  Direction  Handshake        Beat carries
// in_i     sink       valid / ready    sample or window coefficient load
// out_o    source     valid / ready    one bin or one configuration error
// APB      slave      psel / penable   four configuration registers
//
// A load item, or a sample that completes no frame, leaves the sequencer
// idle, but a sample that raises a configuration error does not. A sample
// that completes a frame of N = 2^lg points holds the input for windowing,
// for the butterflies (one shared butterfly unit reading and writing the
// work memory) and for the emission of every bin.
// A stall on out_o holds the sequencer at the current bin; the last beat of
// a frame may wait in the result register while the next item is taken.
// Reset clears the counters and the configuration to their defaults; the
// memories need no clearing pass.
// ============================================================================
module stft_frame_engine_unit #(
  parameter int MAX_FFT_POINTS = stft_pkg::MaxFftPoints,
  parameter int SAMPLE_BITS    = stft_pkg::SampleBits
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  stft_in_if.sink                     in_i,
  stft_out_if.source                  out_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [stft_pkg::CfgAw-1:0]  paddr,
  input  logic [stft_pkg::CfgDw-1:0]  pwdata,
  output logic [stft_pkg::CfgDw-1:0]  prdata,
  output logic                        pready
);
  import stft_pkg::*;

  // Largest transform order that fits the work memory.
  localparam int LGMAX = $clog2(MAX_FFT_POINTS + 1) - 1;

  cfg_t     cfg_q;
  dp_cmd_t  cmd;
  dp_stat_t stat;
  logic     cfg_we;

  // Register writes complete in the access phase; there are no wait states.
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.window_length  <= RST_WINDOW_LENGTH;
      cfg_q.overlap_length <= RST_OVERLAP_LENGTH;
      cfg_q.fft_size_log2  <= RST_FFT_SIZE_LOG2;
      cfg_q.freq_range     <= RST_FREQ_RANGE;
    end else if (cfg_we) begin
      case (paddr[3:2])
        REG_WINDOW_LENGTH:  cfg_q.window_length  <= pwdata[6:0];
        REG_OVERLAP_LENGTH: cfg_q.overlap_length <= pwdata[5:0];
        REG_FFT_SIZE_LOG2:  cfg_q.fft_size_log2  <= pwdata[2:0];
        REG_FREQ_RANGE:     cfg_q.freq_range     <= pwdata[1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_WINDOW_LENGTH:  prdata = CfgDw'(cfg_q.window_length);
      REG_OVERLAP_LENGTH: prdata = CfgDw'(cfg_q.overlap_length);
      REG_FFT_SIZE_LOG2:  prdata = CfgDw'(cfg_q.fft_size_log2);
      REG_FREQ_RANGE:     prdata = CfgDw'(cfg_q.freq_range);
      default:            prdata = '0;
    endcase
  end

  // The sequencer owns framing and loop counters; the datapath only obeys.
  stft_ctrl #(
    .LGMAX (LGMAX)
  ) u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg_q),
    .in_valid_i      (in_i.valid),
    .in_ready_o      (in_i.ready),
    .in_req_type_i   (in_i.req_type),
    .in_first_i      (in_i.first_of_signal),
    .in_coef_index_i (in_i.coef_index),
    .stat_i          (stat),
    .cmd_o           (cmd)
  );

  stft_dp #(
    .LGMAX       (LGMAX),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .sample_i     (in_i.sample),
    .coef_value_i (in_i.coef_value),
    .out_valid_o  (out_o.valid),
    .out_ready_i  (out_o.ready),
    .out_status_o (out_o.status),
    .out_frame_o  (out_o.frame_number),
    .out_pos_o    (out_o.bin_position),
    .out_real_o   (out_o.bin_real),
    .out_imag_o   (out_o.bin_imag),
    .out_last_o   (out_o.last_bin)
  );

endmodule

// ===== hw/rtl/stft_chk.sv =====
`timescale 1ns / 1ps
// ============================================================================
// stft_chk: port-level checks of the STFT frame engine
// Watches the channels of the top level and flags illegal sequences.
// ============================================================================
module stft_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic        in_req_type_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic        out_status_i,
  input logic        out_last_i,
  input logic [5:0]  out_pos_i,
  input logic [23:0] out_real_i,
  input logic [23:0] out_imag_i
);

  // A stalled result beat keeps its payload.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=>
      out_valid_i && $stable(out_real_i) && $stable(out_imag_i) && $stable(out_pos_i))
    else $error("result beat changed while stalled");

  // An error beat is a lone, empty, final beat.
  a_err_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_status_i |->
      out_last_i && out_pos_i == 6'd0 && out_real_i == 24'd0 && out_imag_i == 24'd0)
    else $error("malformed error beat");

  // A window load never produces a result.
  a_load_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && in_req_type_i && !out_valid_i |=> !out_valid_i)
    else $error("result after a window load");

  // While a frame is being emitted, no new input is taken.
  a_frame_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_last_i |-> !in_ready_i)
    else $error("input taken in the middle of a frame");

endmodule

bind stft_frame_engine_unit stft_chk u_stft_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_i.valid),
  .in_ready_i    (in_i.ready),
  .in_req_type_i (in_i.req_type),
  .out_valid_i   (out_o.valid),
  .out_ready_i   (out_o.ready),
  .out_status_i  (out_o.status),
  .out_last_i    (out_o.last_bin),
  .out_pos_i     (out_o.bin_position),
  .out_real_i    (out_o.bin_real),
  .out_imag_i    (out_o.bin_imag)
);
